@@ rtl/rob_pkg.sv @@
// Shared types, codes and helper functions for the raster-op blit engine.
// Depends on nothing; every module of the block imports it.
package rob_pkg;

    // Width of the rectangle size registers and of the reported box size.
    localparam int DIM_W = 13;
    // Width of the reported box offsets.
    localparam int OFS_W = 12;
    // Entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    localparam logic [31:0] ALPHA_MASK = 32'hFF00_0000;
    localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

    // Operation modes.
    typedef enum logic [1:0] {
        MODE_ROP  = 2'd0,
        MODE_COPY = 2'd1,
        MODE_FILL = 2'd2,
        MODE_MASK = 2'd3
    } t_blit_mode;

    // Binary raster operation codes.
    typedef enum logic [3:0] {
        ROP_BLACK    = 4'd0,
        ROP_WHITE    = 4'd1,
        ROP_SRC      = 4'd2,
        ROP_DST      = 4'd3,
        ROP_NSRC     = 4'd4,
        ROP_NDST     = 4'd5,
        ROP_AND      = 4'd6,
        ROP_NAND     = 4'd7,
        ROP_OR       = 4'd8,
        ROP_NOR      = 4'd9,
        ROP_XOR      = 4'd10,
        ROP_XNOR     = 4'd11,
        ROP_AND_NSRC = 4'd12,
        ROP_NAND_NSRC = 4'd13,
        ROP_OR_NSRC  = 4'd14,
        ROP_NOR_NSRC = 4'd15
    } t_rop_code;

    // Configuration register indexes (byte address divided by four).
    typedef enum logic [2:0] {
        REG_MODE         = 3'd0,
        REG_ROP_CODE     = 3'd1,
        REG_IGNORE_ALPHA = 3'd2,
        REG_REVERSE_SCAN = 3'd3,
        REG_FILL_COLOR   = 3'd4,
        REG_RECT_WIDTH   = 3'd5,
        REG_RECT_HEIGHT  = 3'd6
    } t_reg_index;

    // Input word: one source (or mask) pixel and the old destination pixel.
    typedef struct packed {
        logic [31:0] src_pixel;
        logic [31:0] dst_pixel;
    } t_rob_in;

    // Output word: the new pixel with its flags and the changed box.
    typedef struct packed {
        logic [31:0]      new_pixel;
        logic             write_pixel;
        logic             pixel_changed;
        logic             last_of_rect;
        logic [OFS_W-1:0] box_x;
        logic [OFS_W-1:0] box_y;
        logic [DIM_W-1:0] box_width;
        logic [DIM_W-1:0] box_height;
    } t_rob_out;

    // Classified pixel handed from the front to the back.
    typedef struct packed {
        logic [31:0] new_pixel;
        logic        write_pixel;
        logic        pixel_changed;
        logic        last_of_rect;
    } t_rob_job;

    // Configuration as seen by the front and the back, sizes already clamped.
    typedef struct packed {
        t_blit_mode       mode;
        t_rop_code        rop_code;
        logic             ignore_alpha;
        logic             reverse_scan;
        logic [23:0]      fill_color;
        logic [DIM_W-1:0] w_eff;
        logic [DIM_W-1:0] h_eff;
    } t_rob_cfg;

    // The sixteen binary raster operations.
    function automatic logic [31:0] rob_rop(input t_rop_code code,
                                            input logic [31:0] s,
                                            input logic [31:0] d);
        logic [31:0] res;
        case (code)
            ROP_BLACK:     res = ALPHA_MASK;
            ROP_WHITE:     res = ALL_ONES;
            ROP_SRC:       res = s;
            ROP_DST:       res = d;
            ROP_NSRC:      res = ~s;
            ROP_NDST:      res = ~d;
            ROP_AND:       res = d & s;
            ROP_NAND:      res = ~(d & s);
            ROP_OR:        res = d | s;
            ROP_NOR:       res = ~(d | s);
            ROP_XOR:       res = d ^ s;
            ROP_XNOR:      res = ~(d ^ s);
            ROP_AND_NSRC:  res = d & ~s;
            ROP_NAND_NSRC: res = ~(d & ~s);
            ROP_OR_NSRC:   res = d | ~s;
            default:       res = ~(d | ~s);
        endcase
        return res;
    endfunction

endpackage

@@ rtl/raster_op_blit_with_damage_box.sv @@
// Raster-op blit engine with a changed-pixel box: top level with the register port.
// A word accepted at the input is written into the queue, then into the output register; a stall can hold it there.
// Throughput: one word per cycle while the output is not stalled, as the front and back stages are combinational.
// Reset (synchronous, active low) restores the register reset values, the scan
// position and the box, and empties the queue and the output register.
// Depends on rob_pkg, rob_front, rob_queue and rob_back.
module raster_op_blit_with_damage_box import rob_pkg::*; #(
    parameter int MAX_DIM = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_rob_in     i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_rob_out    o_out_word
);

    // Largest size the register can ask for, capped by the parameter.
    localparam int DIM_CAP = (MAX_DIM < (2 ** DIM_W) - 1) ? MAX_DIM : (2 ** DIM_W) - 1;
    localparam int CW = $clog2(DIM_CAP);
    localparam int JOB_W = $bits(t_rob_job) + 2 * CW;

    t_blit_mode       r_mode;
    t_rop_code        r_rop_code;
    logic             r_ignore_alpha;
    logic             r_reverse_scan;
    logic [23:0]      r_fill_color;
    logic [DIM_W-1:0] r_rect_width;
    logic [DIM_W-1:0] r_rect_height;

    t_rob_cfg         cfg;
    t_reg_index       reg_index;
    logic             cfg_write;

    logic             push, pop, queue_valid, queue_full;
    t_rob_job         front_job, back_job;
    logic [CW-1:0]    front_col, front_row, back_col, back_row;
    logic [JOB_W-1:0] queue_head;

    assign pready    = 1'b1;
    assign reg_index = t_reg_index'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_ROP;
            r_rop_code     <= ROP_SRC;
            r_ignore_alpha <= 1'b0;
            r_reverse_scan <= 1'b0;
            r_fill_color   <= '0;
            r_rect_width   <= DIM_W'(1);
            r_rect_height  <= DIM_W'(1);
        end else if (cfg_write) begin
            case (reg_index)
                REG_MODE:         r_mode         <= t_blit_mode'(pwdata[1:0]);
                REG_ROP_CODE:     r_rop_code     <= t_rop_code'(pwdata[3:0]);
                REG_IGNORE_ALPHA: r_ignore_alpha <= pwdata[0];
                REG_REVERSE_SCAN: r_reverse_scan <= pwdata[0];
                REG_FILL_COLOR:   r_fill_color   <= pwdata[23:0];
                REG_RECT_WIDTH:   r_rect_width   <= pwdata[DIM_W-1:0];
                REG_RECT_HEIGHT:  r_rect_height  <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (reg_index)
            REG_MODE:         prdata = 32'(r_mode);
            REG_ROP_CODE:     prdata = 32'(r_rop_code);
            REG_IGNORE_ALPHA: prdata = 32'(r_ignore_alpha);
            REG_REVERSE_SCAN: prdata = 32'(r_reverse_scan);
            REG_FILL_COLOR:   prdata = 32'(r_fill_color);
            REG_RECT_WIDTH:   prdata = 32'(r_rect_width);
            REG_RECT_HEIGHT:  prdata = 32'(r_rect_height);
            default:          prdata = '0;
        endcase
    end

    // Effective configuration: a size of zero acts as one, a large size is capped.
    always_comb begin
        cfg.mode         = r_mode;
        cfg.rop_code     = r_rop_code;
        cfg.ignore_alpha = r_ignore_alpha;
        cfg.reverse_scan = r_reverse_scan;
        cfg.fill_color   = r_fill_color;
        if (r_rect_width == '0) begin
            cfg.w_eff = DIM_W'(1);
        end else if (r_rect_width > DIM_W'(DIM_CAP)) begin
            cfg.w_eff = DIM_W'(DIM_CAP);
        end else begin
            cfg.w_eff = r_rect_width;
        end
        if (r_rect_height == '0) begin
            cfg.h_eff = DIM_W'(1);
        end else if (r_rect_height > DIM_W'(DIM_CAP)) begin
            cfg.h_eff = DIM_W'(DIM_CAP);
        end else begin
            cfg.h_eff = r_rect_height;
        end
    end

    rob_front #(
        .CW(CW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .i_queue_full(queue_full),
        .o_push      (push),
        .o_job       (front_job),
        .o_col       (front_col),
        .o_row       (front_row)
    );

    rob_queue #(
        .WIDTH(JOB_W)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data ({front_job, front_col, front_row}),
        .i_pop  (pop),
        .o_valid(queue_valid),
        .o_full (queue_full),
        .o_data (queue_head)
    );

    assign {back_job, back_col, back_row} = queue_head;

    rob_back #(
        .CW(CW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_job_valid(queue_valid),
        .i_job      (back_job),
        .i_col      (back_col),
        .i_row      (back_row),
        .o_pop      (pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

endmodule

@@ rtl/rob_front.sv @@
// Front of the blit engine: accepts pixel words, computes the new pixel and its
// flags, and tracks the scan position. Depends on rob_pkg.
module rob_front import rob_pkg::*; #(
    parameter int CW = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_rob_cfg      i_cfg,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  t_rob_in       i_in_word,
    input  logic          i_queue_full,
    output logic          o_push,
    output t_rob_job      o_job,
    output logic [CW-1:0] o_col,
    output logic [CW-1:0] o_row
);

    logic [CW-1:0] r_scan_col, n_scan_col;
    logic [CW-1:0] r_scan_row, n_scan_row;
    logic [CW-1:0] wm1, hm1;
    logic [31:0]   fill_pixel;
    logic          take;
    logic          row_end;
    logic          last_pixel;

    // Accept whenever the queue has room.
    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    assign wm1        = CW'(i_cfg.w_eff - DIM_W'(1));
    assign hm1        = CW'(i_cfg.h_eff - DIM_W'(1));
    assign fill_pixel = ALPHA_MASK | {8'h00, i_cfg.fill_color};

    // Work out the new pixel; a pixel left alone keeps the destination value.
    always_comb begin
        take            = 1'b0;
        o_job.new_pixel = i_in_word.dst_pixel;
        case (i_cfg.mode)
            MODE_ROP: begin
                o_job.new_pixel = rob_rop(i_cfg.rop_code, i_in_word.src_pixel,
                                          i_in_word.dst_pixel);
            end
            MODE_COPY: begin
                if (i_cfg.ignore_alpha || (i_in_word.src_pixel & ALPHA_MASK) != '0) begin
                    o_job.new_pixel = i_in_word.src_pixel | ALPHA_MASK;
                end
            end
            MODE_FILL: begin
                o_job.new_pixel = fill_pixel;
            end
            default: begin
                take = (i_in_word.src_pixel & ALPHA_MASK) != '0;
                if (take) begin
                    o_job.new_pixel = fill_pixel;
                end
            end
        endcase
        o_job.pixel_changed = o_job.new_pixel != i_in_word.dst_pixel;
        o_job.write_pixel   = (i_cfg.mode == MODE_MASK) ? take : o_job.pixel_changed;
        o_job.last_of_rect  = last_pixel;
    end

    // Row and rectangle ends, and the next scan position.
    always_comb begin
        row_end    = r_scan_col >= wm1;
        last_pixel = row_end && (r_scan_row >= hm1);
        n_scan_col = r_scan_col + CW'(1);
        n_scan_row = r_scan_row;
        if (last_pixel) begin
            n_scan_col = '0;
            n_scan_row = '0;
        end else if (row_end) begin
            n_scan_col = '0;
            n_scan_row = r_scan_row + CW'(1);
        end
    end

    assign o_col = r_scan_col;
    assign o_row = r_scan_row;

    // Scan position advances on every accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_col <= '0;
            r_scan_row <= '0;
        end else if (o_push) begin
            r_scan_col <= n_scan_col;
            r_scan_row <= n_scan_row;
        end
    end

endmodule

@@ rtl/rob_queue.sv @@
// Short first-in first-out queue that decouples the front from the back.
// Depends on rob_pkg for its depth.
module rob_queue import rob_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_valid = r_count != '0;
    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_data  = r_mem[r_rd_ptr];

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/rob_back.sv @@
// Back of the blit engine: takes classified pixels from the queue, tracks the
// box of changed pixels and drives the output register. Depends on rob_pkg.
module rob_back import rob_pkg::*; #(
    parameter int CW = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_rob_cfg      i_cfg,
    input  logic          i_job_valid,
    input  t_rob_job      i_job,
    input  logic [CW-1:0] i_col,
    input  logic [CW-1:0] i_row,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output t_rob_out      o_out_word
);

    logic [CW-1:0] r_min_col, n_min_col;
    logic [CW-1:0] r_min_row, n_min_row;
    logic [CW-1:0] r_max_col, n_max_col;
    logic [CW-1:0] r_max_row, n_max_row;
    logic          r_any, n_any;
    logic          r_out_valid;
    t_rob_out      r_out_word, n_out_word;
    logic [CW-1:0] wm1, hm1;
    logic [CW-1:0] lc, hc, lr, hr;
    logic [CW-1:0] bx, by;
    logic [DIM_W-1:0] bx_ext, by_ext;

    // Take the next word when the output register is free or being emptied.
    assign o_pop       = i_job_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign wm1 = CW'(i_cfg.w_eff - DIM_W'(1));
    assign hm1 = CW'(i_cfg.h_eff - DIM_W'(1));

    // Grow the box with this pixel when it changed.
    always_comb begin
        n_min_col = r_min_col;
        n_min_row = r_min_row;
        n_max_col = r_max_col;
        n_max_row = r_max_row;
        n_any     = r_any;
        if (i_job.pixel_changed) begin
            n_any = 1'b1;
            if (!r_any) begin
                n_min_col = i_col;
                n_max_col = i_col;
                n_min_row = i_row;
                n_max_row = i_row;
            end else begin
                if (i_col < r_min_col) n_min_col = i_col;
                if (i_col > r_max_col) n_max_col = i_col;
                if (i_row < r_min_row) n_min_row = i_row;
                if (i_row > r_max_row) n_max_row = i_row;
            end
        end
    end

    // Clamp the box to the current size and mirror it back for reversed scans.
    always_comb begin
        lc = (n_min_col < wm1) ? n_min_col : wm1;
        hc = (n_max_col < wm1) ? n_max_col : wm1;
        lr = (n_min_row < hm1) ? n_min_row : hm1;
        hr = (n_max_row < hm1) ? n_max_row : hm1;
        bx = i_cfg.reverse_scan ? (wm1 - hc) : lc;
        by = i_cfg.reverse_scan ? (hm1 - hr) : lr;
        bx_ext = DIM_W'(bx);
        by_ext = DIM_W'(by);
    end

    // Assemble the output word.
    always_comb begin
        n_out_word.new_pixel     = i_job.new_pixel;
        n_out_word.write_pixel   = i_job.write_pixel;
        n_out_word.pixel_changed = i_job.pixel_changed;
        n_out_word.last_of_rect  = i_job.last_of_rect;
        n_out_word.box_x         = '0;
        n_out_word.box_y         = '0;
        n_out_word.box_width     = '0;
        n_out_word.box_height    = '0;
        if (i_job.last_of_rect) begin
            if (i_cfg.mode == MODE_MASK) begin
                n_out_word.box_width  = i_cfg.w_eff;
                n_out_word.box_height = i_cfg.h_eff;
            end else if (n_any) begin
                n_out_word.box_x      = bx_ext[OFS_W-1:0];
                n_out_word.box_y      = by_ext[OFS_W-1:0];
                n_out_word.box_width  = DIM_W'(hc) - DIM_W'(lc) + DIM_W'(1);
                n_out_word.box_height = DIM_W'(hr) - DIM_W'(lr) + DIM_W'(1);
            end
        end
    end

    // Box registers; they return to zero after the last pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_col <= '0;
            r_min_row <= '0;
            r_max_col <= '0;
            r_max_row <= '0;
            r_any     <= 1'b0;
        end else if (o_pop) begin
            if (i_job.last_of_rect) begin
                r_min_col <= '0;
                r_min_row <= '0;
                r_max_col <= '0;
                r_max_row <= '0;
                r_any     <= 1'b0;
            end else begin
                r_min_col <= n_min_col;
                r_min_row <= n_min_row;
                r_max_col <= n_max_col;
                r_max_row <= n_max_row;
                r_any     <= n_any;
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_word <= n_out_word;
        end
    end

endmodule

@@ rtl/rob_checker.sv @@
// Port-level checks on the output channel of the blit engine, bound to the top level.
// Depends on rob_pkg.
module rob_checker import rob_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_out_valid,
    input logic     i_out_stall,
    input t_rob_out i_out_word
);

    // A stalled word stays offered.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid)
        else $error("output valid dropped while stalled");

    // A stalled word keeps its contents.
    a_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> $stable(i_out_word))
        else $error("output word changed while stalled");

    // The box is only reported with the last pixel of a rectangle.
    a_box_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_word.last_of_rect |->
            i_out_word.box_x == '0 && i_out_word.box_y == '0 &&
            i_out_word.box_width == '0 && i_out_word.box_height == '0)
        else $error("box reported before the last pixel");

    // A box is either empty in both directions or in neither.
    a_box_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_word.last_of_rect |->
            (i_out_word.box_width == '0) == (i_out_word.box_height == '0))
        else $error("box empty in one direction only");

    // An empty box sits at the origin.
    a_empty_at_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_word.box_width == '0 |->
            i_out_word.box_x == '0 && i_out_word.box_y == '0)
        else $error("empty box away from the origin");

endmodule

bind raster_op_blit_with_damage_box rob_checker u_rob_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .i_out_word (o_out_word)
);

@@ dv/raster_op_blit_with_damage_box_tb.sv @@
// Self-checking testbench for the raster-op blit engine with its changed-pixel box.
// Drives pixel words and register writes, predicts every output word and checks it.
// Depends on rob_pkg and raster_op_blit_with_damage_box.
module raster_op_blit_with_damage_box_tb;
    import rob_pkg::*;

    localparam int MAX_DIM     = 4096;
    localparam int MAX_REPORTS = 10;

    // Predicts the output words and checks them against what the block delivers.
    class blit_scoreboard;
        t_blit_mode       mode;
        t_rop_code        rop;
        logic             ignore_alpha;
        logic             reverse_scan;
        logic [23:0]      fill_color;
        logic [DIM_W-1:0] rect_w;
        logic [DIM_W-1:0] rect_h;
        logic [OFS_W-1:0] col, row, min_col, min_row, max_col, max_row;
        logic             any_change;
        t_rob_out         expected_words[$];
        int               errors;

        function new();
            mode         = MODE_ROP;
            rop          = ROP_SRC;
            ignore_alpha = 1'b0;
            reverse_scan = 1'b0;
            fill_color   = '0;
            rect_w       = DIM_W'(1);
            rect_h       = DIM_W'(1);
            errors       = 0;
            clear_box();
        endfunction

        function void clear_box();
            col        = '0;
            row        = '0;
            min_col    = '0;
            min_row    = '0;
            max_col    = '0;
            max_row    = '0;
            any_change = 1'b0;
        endfunction

        // Mirrors a register write into the predictor's copy of the settings.
        function void write_reg(t_reg_index idx, logic [31:0] value);
            case (idx)
                REG_MODE:         mode = t_blit_mode'(value[1:0]);
                REG_ROP_CODE:     rop = t_rop_code'(value[3:0]);
                REG_IGNORE_ALPHA: ignore_alpha = value[0];
                REG_REVERSE_SCAN: reverse_scan = value[0];
                REG_FILL_COLOR:   fill_color = value[23:0];
                REG_RECT_WIDTH:   rect_w = value[DIM_W-1:0];
                REG_RECT_HEIGHT:  rect_h = value[DIM_W-1:0];
                default: ;
            endcase
        endfunction

        // A size of zero behaves as one; anything above the maximum is held at it.
        function int unsigned eff_dim(logic [DIM_W-1:0] v);
            if (v == 0) return 1;
            if (v > MAX_DIM) return MAX_DIM;
            return v;
        endfunction

        function logic [31:0] raster(t_rop_code code, logic [31:0] s, logic [31:0] d);
            case (code)
                ROP_BLACK:     return ALPHA_MASK;
                ROP_WHITE:     return ALL_ONES;
                ROP_SRC:       return s;
                ROP_DST:       return d;
                ROP_NSRC:      return ~s;
                ROP_NDST:      return ~d;
                ROP_AND:       return s & d;
                ROP_NAND:      return ~(s & d);
                ROP_OR:        return s | d;
                ROP_NOR:       return ~(s | d);
                ROP_XOR:       return s ^ d;
                ROP_XNOR:      return ~(s ^ d);
                ROP_AND_NSRC:  return d & ~s;
                ROP_NAND_NSRC: return ~(d & ~s);
                ROP_OR_NSRC:   return d | ~s;
                default:       return ~(d | ~s);
            endcase
        endfunction

        // Works out the output word for one pixel and advances the scan and the box.
        function t_rob_out blit_pixel(t_rob_in word);
            t_rob_out    r;
            int unsigned w, h, lc, hc, lr, hr;
            logic [31:0] colour;
            logic [31:0] s, d;
            s      = word.src_pixel;
            d      = word.dst_pixel;
            w      = eff_dim(rect_w);
            h      = eff_dim(rect_h);
            colour = ALPHA_MASK | {8'h00, fill_color};
            r      = '0;
            r.new_pixel = d;
            case (mode)
                MODE_ROP: begin
                    r.new_pixel     = raster(rop, s, d);
                    r.pixel_changed = (r.new_pixel != d);
                    r.write_pixel   = r.pixel_changed;
                end
                MODE_COPY: begin
                    // A transparent source pixel leaves the destination alone unless alpha is ignored.
                    if (ignore_alpha || s[31:24] != 8'h00) begin
                        r.new_pixel     = s | ALPHA_MASK;
                        r.pixel_changed = (r.new_pixel != d);
                        r.write_pixel   = r.pixel_changed;
                    end
                end
                MODE_FILL: begin
                    r.new_pixel     = colour;
                    r.pixel_changed = (r.new_pixel != d);
                    r.write_pixel   = r.pixel_changed;
                end
                default: begin
                    // The mask writes wherever its alpha is set, changed or not.
                    if (s[31:24] != 8'h00) begin
                        r.new_pixel     = colour;
                        r.write_pixel   = 1'b1;
                        r.pixel_changed = (r.new_pixel != d);
                    end
                end
            endcase

            // Grow the box of changed pixels in scan coordinates.
            if (r.pixel_changed) begin
                if (!any_change) begin
                    min_col    = col;
                    max_col    = col;
                    min_row    = row;
                    max_row    = row;
                    any_change = 1'b1;
                end else begin
                    if (col < min_col) min_col = col;
                    if (col > max_col) max_col = col;
                    if (row < min_row) min_row = row;
                    if (row > max_row) max_row = row;
                end
            end

            // Step the scan position; the last pixel reports the box and clears it.
            if (int'(col) >= w - 1) begin
                if (int'(row) >= h - 1) begin
                    r.last_of_rect = 1'b1;
                    if (mode == MODE_MASK) begin
                        r.box_width  = DIM_W'(w);
                        r.box_height = DIM_W'(h);
                    end else if (any_change) begin
                        lc = (min_col < w - 1) ? min_col : w - 1;
                        hc = (max_col < w - 1) ? max_col : w - 1;
                        lr = (min_row < h - 1) ? min_row : h - 1;
                        hr = (max_row < h - 1) ? max_row : h - 1;
                        if (reverse_scan) begin
                            r.box_x = OFS_W'(w - 1 - hc);
                            r.box_y = OFS_W'(h - 1 - hr);
                        end else begin
                            r.box_x = OFS_W'(lc);
                            r.box_y = OFS_W'(lr);
                        end
                        r.box_width  = DIM_W'(hc - lc + 1);
                        r.box_height = DIM_W'(hr - lr + 1);
                    end
                    clear_box();
                end else begin
                    col = '0;
                    row = row + 1'b1;
                end
            end else begin
                col = col + 1'b1;
            end
            return r;
        endfunction

        // Notes an accepted input word; returns whether it closes the rectangle.
        function logic note_pixel(t_rob_in word);
            t_rob_out e;
            e = blit_pixel(word);
            expected_words.push_back(e);
            return e.last_of_rect;
        endfunction

        function void report(string what);
            errors++;
            if (errors <= MAX_REPORTS) $display("%s", what);
        endfunction

        // Compares a delivered output word with the oldest prediction.
        function void check_word(t_rob_out act);
            t_rob_out e;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected output word: px=%h last=%b", act.new_pixel,
                                 act.last_of_rect));
                return;
            end
            e = expected_words.pop_front();
            if (act.new_pixel !== e.new_pixel || act.write_pixel !== e.write_pixel ||
                act.pixel_changed !== e.pixel_changed || act.last_of_rect !== e.last_of_rect ||
                act.box_x !== e.box_x || act.box_y !== e.box_y ||
                act.box_width !== e.box_width || act.box_height !== e.box_height) begin
                report($sformatf({"mismatch: expected px=%h wr=%b ch=%b last=%b box=%0d,%0d %0dx%0d",
                                  " got px=%h wr=%b ch=%b last=%b box=%0d,%0d %0dx%0d"},
                                 e.new_pixel, e.write_pixel, e.pixel_changed, e.last_of_rect,
                                 e.box_x, e.box_y, e.box_width, e.box_height,
                                 act.new_pixel, act.write_pixel, act.pixel_changed,
                                 act.last_of_rect, act.box_x, act.box_y, act.box_width,
                                 act.box_height));
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_stall;
    t_rob_in     i_in_word;
    logic        o_out_valid;
    logic        i_out_stall;
    t_rob_out    o_out_word;

    blit_scoreboard sb = new();
    bit             no_idle = 1'b0;
    int             pixels_sent = 0;
    t_blit_mode     cur_mode = MODE_ROP;
    logic [23:0]    cur_fill = '0;

    raster_op_blit_with_damage_box #(
        .MAX_DIM(MAX_DIM)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit on the run, far beyond the slowest correct one.
    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

    // Output words are sampled mid-cycle, where nothing is changing.
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_word(o_out_word);
    end

    // Receiver: raises the stall for a random gap, which may be empty, before taking each word.
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 4);
            if (gap != 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            forever begin
                @(negedge i_clk);
                if (o_out_valid) break;
            end
            @(posedge i_clk);
        end
    end

    // Register write over the APB port, only once the block has drained.
    task automatic write_reg(t_reg_index idx, logic [31:0] value);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        forever begin
            @(negedge i_clk);
            if (pready) break;
        end
        @(posedge i_clk);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_blit(t_blit_mode m, t_rop_code r, logic ign, logic rev,
                                logic [23:0] fill, logic [DIM_W-1:0] w,
                                logic [DIM_W-1:0] h);
        cur_mode = m;
        cur_fill = fill;
        write_reg(REG_MODE, 32'(m));
        write_reg(REG_ROP_CODE, 32'(r));
        write_reg(REG_IGNORE_ALPHA, 32'(ign));
        write_reg(REG_REVERSE_SCAN, 32'(rev));
        write_reg(REG_FILL_COLOR, 32'(fill));
        write_reg(REG_RECT_WIDTH, 32'(w));
        write_reg(REG_RECT_HEIGHT, 32'(h));
    endtask

    // Sends one pixel word after a random gap; called and returning at a rising edge.
    task automatic send_pixel(logic [31:0] s, logic [31:0] d, output logic last);
        int      gap;
        t_rob_in word;
        word.src_pixel = s;
        word.dst_pixel = d;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= word;
        forever begin
            @(negedge i_clk);
            if (!o_in_stall) break;
        end
        last = sb.note_pixel(word);
        pixels_sent++;
        @(posedge i_clk);
    endtask

    // Random pixel pair, biased towards transparent sources and unchanged destinations.
    task automatic send_random(output logic last);
        logic [31:0] s, d, colour;
        int          k;
        s = $urandom;
        d = $urandom;
        k = $urandom_range(0, 9);
        if (k < 3) s[31:24] = 8'h00;
        else if (k == 3) s = '0;
        else if (k == 4) s = ALL_ONES;
        colour = ALPHA_MASK | {8'h00, cur_fill};
        k = $urandom_range(0, 9);
        if (k < 3) begin
            case (cur_mode)
                MODE_ROP:  d = s;
                MODE_COPY: d = s | ALPHA_MASK;
                default:   d = colour;
            endcase
        end else if (k == 3) begin
            d = '0;
        end else if (k == 4) begin
            d = ALL_ONES;
        end
        send_pixel(s, d, last);
    endtask

    function automatic logic [DIM_W-1:0] pick_small_dim(int unsigned top);
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return '0;
        if (k < 16) return DIM_W'($urandom_range(1, top));
        return DIM_W'($urandom_range(1, 24));
    endfunction

    function automatic logic [DIM_W-1:0] pick_wide_dim();
        case ($urandom_range(0, 3))
            0:       return DIM_W'(MAX_DIM);
            1:       return '1;
            2:       return DIM_W'($urandom_range(MAX_DIM + 1, 8191));
            default: return DIM_W'($urandom_range(1, MAX_DIM));
        endcase
    endfunction

    function automatic logic [23:0] pick_fill();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return 24'($urandom);
        endcase
    endfunction

    // Stimulus.
    initial begin
        logic        last;
        t_rop_code   code;
        int          n;
        i_rst_n     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        i_in_valid  <= 1'b0;
        i_in_word   <= '0;
        i_out_stall <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings are a 1x1 source raster op; unchanged then changed pixel.
        send_pixel(32'h0000_0000, 32'h0000_0000, last);
        send_pixel(ALL_ONES, 32'h0000_0000, last);

        // Every raster op once, extremes on alternate codes.
        code = code.first();
        n = 0;
        do begin
            write_reg(REG_ROP_CODE, 32'(code));
            if (n % 2 == 0) send_pixel(32'h0000_0000, ALL_ONES, last);
            else send_pixel($urandom, $urandom, last);
            code = code.next();
            n++;
        end while (code != code.first());

        // Copy of a transparent source, skipped and then forced.
        write_reg(REG_MODE, 32'(MODE_COPY));
        cur_mode = MODE_COPY;
        send_pixel(32'h00AB_CDEF, 32'h1234_5678, last);
        write_reg(REG_IGNORE_ALPHA, 32'd1);
        send_pixel(32'h00AB_CDEF, 32'h1234_5678, last);

        // Solid fill over a pixel that already holds the colour, then over black.
        write_reg(REG_MODE, 32'(MODE_FILL));
        write_reg(REG_FILL_COLOR, 32'hFF_FFFF);
        cur_mode = MODE_FILL;
        cur_fill = 24'hFF_FFFF;
        send_pixel($urandom, ALL_ONES, last);
        send_pixel($urandom, 32'h0000_0000, last);

        // Mask fill: zero mask alpha, then a write that changes nothing.
        write_reg(REG_MODE, 32'(MODE_MASK));
        write_reg(REG_FILL_COLOR, 32'h00_0000);
        cur_mode = MODE_MASK;
        cur_fill = '0;
        send_pixel(32'h00FF_FFFF, $urandom, last);
        send_pixel(32'h0100_0000, ALPHA_MASK, last);

        // Random phases: mostly whole small rectangles, sometimes a partial scan
        // at extreme sizes that the next phase then cuts short.
        while (pixels_sent < 1325) begin
            no_idle = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 5) == 0) begin
                program_blit(t_blit_mode'($urandom_range(0, 3)),
                             t_rop_code'($urandom_range(0, 15)),
                             1'($urandom), 1'($urandom), pick_fill(), pick_wide_dim(),
                             $urandom_range(0, 1) ? pick_wide_dim() : pick_small_dim(5));
                n = $urandom_range(1, 30);
                repeat (n) send_random(last);
            end else begin
                program_blit(t_blit_mode'($urandom_range(0, 3)),
                             t_rop_code'($urandom_range(0, 15)),
                             1'($urandom), 1'($urandom), pick_fill(), pick_small_dim(8),
                             pick_small_dim(5));
                n = $urandom_range(1, 3);
                repeat (n) begin
                    last = 1'b0;
                    while (!last) send_random(last);
                end
            end
        end
        i_in_valid <= 1'b0;
        no_idle = 1'b0;

        // Drain and let the pipeline settle before the verdict.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/rob_pkg.sv
rtl/rob_front.sv
rtl/rob_queue.sv
rtl/rob_back.sv
rtl/raster_op_blit_with_damage_box.sv
rtl/rob_checker.sv
dv/raster_op_blit_with_damage_box_tb.sv
